FILE: design/assert_macros.svh
// Assertion macros shared by the lamp controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ALM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

FILE: design/alm_pkg.sv
// Shared types and constants for the exterior-lamp mode controller.
`timescale 1ns / 1ps
`default_nettype none

package alm_pkg;

    localparam int unsigned TICK_MS_DEF = 10;
    localparam int unsigned MS_PER_S    = 1000;
    localparam int unsigned CD_W        = 15;
    localparam int unsigned CD_MAX      = 32767;
    localparam int unsigned SECS_W      = 8;
    localparam int unsigned LAMP_W      = 3;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WELCOME_SECONDS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOODBYE_SECONDS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WELCOME_LAMPS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOODBYE_LAMPS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_LAMPS_ENABLED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_LAMPS         = 3'd5;

    // Lamp masks: bit0 parking, bit1 xenon, bit2 fog.
    localparam logic [LAMP_W-1:0] LAMPS_OFF = 3'b000;
    localparam logic [LAMP_W-1:0] LAMPS_DRL = 3'b011;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_WELCOME = 3'd1,
        MODE_ACC     = 3'd2,
        MODE_DRL     = 3'd3,
        MODE_GOODBYE = 3'd4,
        MODE_MANUAL  = 3'd5
    } t_mode;

    typedef struct packed {
        logic ignition_on;
        logic auto_selected;
        logic engine_running;
        logic unlock_event;
    } t_in;

    typedef struct packed {
        logic [2:0]        mode_out;
        logic [LAMP_W-1:0] lamps;
    } t_out;

    // Durations are kept as tick counts, already converted at write time.
    typedef struct packed {
        logic [CD_W-1:0]   welcome_ticks;
        logic [CD_W-1:0]   goodbye_ticks;
        logic [LAMP_W-1:0] welcome_lamps;
        logic [LAMP_W-1:0] goodbye_lamps;
        logic              acc_lamps_enabled;
        logic [LAMP_W-1:0] acc_lamps;
    } t_cfg;

endpackage

`default_nettype wire

FILE: design/alm_core.sv
// Mode state machine, countdown and lamp drive of the lamp controller.
`timescale 1ns / 1ps
`default_nettype none

module alm_core import alm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire t_in  i_tick,
    input  wire t_cfg i_cfg,
    output t_out      o_result
);

    t_mode             r_mode, n_mode;
    logic [CD_W-1:0]   r_countdown, n_countdown, w_cd_dec;
    logic [LAMP_W-1:0] r_lamps, n_lamps;
    logic              w_ign, w_auto, w_eng, w_unlock, w_enter;

    assign w_ign    = i_tick.ignition_on;
    assign w_auto   = i_tick.auto_selected;
    assign w_eng    = i_tick.engine_running;
    assign w_unlock = i_tick.unlock_event;

    // The countdown drops before the mode rules look at it.
    assign w_cd_dec = r_countdown - CD_W'(r_countdown != '0);

    // Next state.
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_OFF: begin
                if (w_ign && !w_auto)                          n_mode = MODE_MANUAL;
                else if (w_ign && w_eng)                       n_mode = MODE_DRL;
                else if (w_ign)                                n_mode = MODE_ACC;
                else if (w_unlock && i_cfg.welcome_ticks != '0) n_mode = MODE_WELCOME;
            end
            MODE_WELCOME: begin
                if (w_ign && !w_auto)      n_mode = MODE_MANUAL;
                else if (w_ign && w_eng)   n_mode = MODE_DRL;
                else if (w_ign)            n_mode = MODE_ACC;
                else if (w_cd_dec == '0)   n_mode = MODE_OFF;
            end
            MODE_ACC: begin
                if (!w_ign)       n_mode = MODE_OFF;
                else if (!w_auto) n_mode = MODE_MANUAL;
                else if (w_eng)   n_mode = MODE_DRL;
            end
            MODE_DRL: begin
                if (!w_ign && !w_eng) n_mode = MODE_OFF;
                else if (!w_auto)     n_mode = MODE_MANUAL;
                else if (!w_eng) begin
                    n_mode = (i_cfg.goodbye_ticks != '0) ? MODE_GOODBYE : MODE_ACC;
                end
            end
            MODE_GOODBYE: begin
                if (w_eng)                n_mode = MODE_DRL;
                else if (!w_ign)          n_mode = MODE_OFF;
                else if (w_cd_dec == '0)  n_mode = MODE_ACC;
            end
            MODE_MANUAL: begin
                if (!w_ign)      n_mode = MODE_OFF;
                else if (w_auto) n_mode = w_eng ? MODE_DRL : MODE_ACC;
            end
            default: ;
        endcase
    end

    // No rule leads back to the mode it starts from, so a change means an entry.
    assign w_enter = (n_mode != r_mode);

    // Entry actions.
    always_comb begin
        n_countdown = w_cd_dec;
        n_lamps     = r_lamps;
        if (w_enter) begin
            case (n_mode)
                MODE_WELCOME: begin
                    n_countdown = i_cfg.welcome_ticks;
                    n_lamps     = i_cfg.welcome_lamps;
                end
                MODE_ACC: begin
                    n_countdown = '0;
                    n_lamps     = i_cfg.acc_lamps_enabled ? i_cfg.acc_lamps : LAMPS_OFF;
                end
                MODE_DRL: begin
                    n_countdown = '0;
                    n_lamps     = LAMPS_DRL;
                end
                MODE_GOODBYE: begin
                    n_countdown = i_cfg.goodbye_ticks;
                    n_lamps     = i_cfg.goodbye_lamps;
                end
                default: begin
                    n_countdown = '0;
                    n_lamps     = LAMPS_OFF;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_countdown <= '0;
            r_lamps     <= LAMPS_OFF;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_countdown <= n_countdown;
            r_lamps     <= n_lamps;
        end
    end

    assign o_result.mode_out = n_mode;
    assign o_result.lamps    = n_lamps;

endmodule

`default_nettype wire

FILE: design/auto_lamp_mode_controller.sv
// Top level of the exterior-lamp mode controller.
//
//   channel | direction | handshake                      | payload
//   --------+-----------+--------------------------------+------------------------
//   in      | input     | i_in_valid / o_in_ready        | i_in_data  (t_in)
//   out     | output    | o_out_valid / i_out_ready      | o_out_data (t_out)
//   cfg     | input     | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One tick item is taken per cycle while the input side is not stalled; its result appears in the cycle after.
// The mode logic sits between the state registers and the output register.
// A full output register that is not being taken stalls the input side.
// Reset is synchronous and active low; it returns the block to off, all lamps dark.
// Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module auto_lamp_mode_controller import alm_pkg::*; #(
    parameter int unsigned TICK_MS = TICK_MS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CD_W-1:0] w_tick_table [2**SECS_W];
    t_cfg            r_cfg;
    t_out            w_result, r_out_data;
    logic            r_out_valid, w_in_ready, w_in_fire;

    // Seconds to ticks, truncated and saturated to the countdown width.
    for (genvar g = 0; g < 2**SECS_W; g++) begin : g_ticks
        localparam int unsigned RAW = (g * MS_PER_S) / TICK_MS;
        assign w_tick_table[g] = (RAW > CD_MAX) ? CD_W'(CD_MAX) : CD_W'(RAW);
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WELCOME_SECONDS:   r_cfg.welcome_ticks     <= w_tick_table[i_cfg_data];
                CFG_GOODBYE_SECONDS:   r_cfg.goodbye_ticks     <= w_tick_table[i_cfg_data];
                CFG_WELCOME_LAMPS:     r_cfg.welcome_lamps     <= i_cfg_data[LAMP_W-1:0];
                CFG_GOODBYE_LAMPS:     r_cfg.goodbye_lamps     <= i_cfg_data[LAMP_W-1:0];
                CFG_ACC_LAMPS_ENABLED: r_cfg.acc_lamps_enabled <= i_cfg_data[0];
                CFG_ACC_LAMPS:         r_cfg.acc_lamps         <= i_cfg_data[LAMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_in_ready = !r_out_valid || i_out_ready;
    assign w_in_fire  = i_in_valid && w_in_ready;
    assign o_in_ready = w_in_ready;

    alm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_in_fire),
        .i_tick   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ALM_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_in_fire, o_out_valid)
    `ALM_ASSERT_IMP(a_drl_lamps, i_clk, i_rst_n, o_out_valid && o_out_data.mode_out == MODE_DRL, o_out_data.lamps == LAMPS_DRL)
    `ALM_ASSERT_IMP(a_dark_modes, i_clk, i_rst_n, o_out_valid && (o_out_data.mode_out == MODE_OFF || o_out_data.mode_out == MODE_MANUAL), o_out_data.lamps == LAMPS_OFF)

endmodule

`default_nettype wire

FILE: tb/sv/tb_auto_lamp_mode_controller.sv
// Self-checking testbench for the exterior-lamp mode controller.
`timescale 1ns / 1ps

module tb_auto_lamp_mode_controller;
    import alm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    // Tracks the controller's mode, countdown and lamp drive and holds the lamp
    // drive items that the block still owes.
    class lamp_mode_scoreboard;
        logic [SECS_W-1:0] welcome_secs;
        logic [SECS_W-1:0] goodbye_secs;
        logic [LAMP_W-1:0] welcome_mask;
        logic [LAMP_W-1:0] goodbye_mask;
        logic [LAMP_W-1:0] acc_mask;
        logic              acc_mask_on;
        t_mode             mode;
        logic [CD_W-1:0]   countdown;
        logic [LAMP_W-1:0] drive;
        t_out              expected_drive[$];
        int                errors;

        function new();
            welcome_secs = '0;
            goodbye_secs = '0;
            welcome_mask = '0;
            goodbye_mask = '0;
            acc_mask = '0;
            acc_mask_on = 1'b0;
            mode = MODE_OFF;
            countdown = '0;
            drive = LAMPS_OFF;
            errors = 0;
        endfunction

        function logic [CD_W-1:0] duration_ticks(logic [SECS_W-1:0] secs);
            int unsigned t;
            t = 32'(secs) * MS_PER_S / TICK_MS_DEF;
            if (t > CD_MAX) begin
                t = CD_MAX;
            end
            return CD_W'(t);
        endfunction

        function void enter_mode(t_mode m);
            mode = m;
            countdown = '0;
            case (m)
                MODE_WELCOME: begin
                    countdown = duration_ticks(welcome_secs);
                    drive = welcome_mask;
                end
                MODE_ACC: drive = acc_mask_on ? acc_mask : LAMPS_OFF;
                MODE_DRL: drive = LAMPS_DRL;
                MODE_GOODBYE: begin
                    countdown = duration_ticks(goodbye_secs);
                    drive = goodbye_mask;
                end
                default: drive = LAMPS_OFF;
            endcase
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_WELCOME_SECONDS: welcome_secs = val;
                CFG_GOODBYE_SECONDS: goodbye_secs = val;
                CFG_WELCOME_LAMPS: welcome_mask = val[LAMP_W-1:0];
                CFG_GOODBYE_LAMPS: goodbye_mask = val[LAMP_W-1:0];
                CFG_ACC_LAMPS_ENABLED: acc_mask_on = val[0];
                CFG_ACC_LAMPS: acc_mask = val[LAMP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(t_in t);
            t_out res;
            logic ign;
            logic auto_sw;
            logic eng;
            ign = t.ignition_on;
            auto_sw = t.auto_selected;
            eng = t.engine_running;
            if (countdown != '0) begin
                countdown = countdown - 1'b1;
            end
            case (mode)
                MODE_OFF: begin
                    if (ign && !auto_sw) enter_mode(MODE_MANUAL);
                    else if (ign && eng) enter_mode(MODE_DRL);
                    else if (ign) enter_mode(MODE_ACC);
                    else if (t.unlock_event && welcome_secs != '0) enter_mode(MODE_WELCOME);
                end
                MODE_WELCOME: begin
                    if (ign && !auto_sw) enter_mode(MODE_MANUAL);
                    else if (ign && eng) enter_mode(MODE_DRL);
                    else if (ign) enter_mode(MODE_ACC);
                    else if (countdown == '0) enter_mode(MODE_OFF);
                end
                MODE_ACC: begin
                    if (!ign) enter_mode(MODE_OFF);
                    else if (!auto_sw) enter_mode(MODE_MANUAL);
                    else if (eng) enter_mode(MODE_DRL);
                end
                MODE_DRL: begin
                    if (!ign && !eng) enter_mode(MODE_OFF);
                    else if (!auto_sw) enter_mode(MODE_MANUAL);
                    else if (!eng) enter_mode(goodbye_secs != '0 ? MODE_GOODBYE : MODE_ACC);
                end
                MODE_GOODBYE: begin
                    if (eng) enter_mode(MODE_DRL);
                    else if (!ign) enter_mode(MODE_OFF);
                    else if (countdown == '0) enter_mode(MODE_ACC);
                end
                MODE_MANUAL: begin
                    if (!ign) enter_mode(MODE_OFF);
                    else if (auto_sw) enter_mode(eng ? MODE_DRL : MODE_ACC);
                end
                default: ;
            endcase
            res.mode_out = mode;
            res.lamps = drive;
            expected_drive.push_back(res);
        endfunction

        function void check_drive(t_out got);
            t_out want;
            if (expected_drive.size() == 0) begin
                $error("unexpected item: mode_out %0d lamps %03b", got.mode_out, got.lamps);
                errors++;
                return;
            end
            want = expected_drive.pop_front();
            if (got.mode_out !== want.mode_out) begin
                $error("mode_out: expected %0d, actual %0d", want.mode_out, got.mode_out);
                errors++;
            end
            if (got.lamps !== want.lamps) begin
                $error("lamps: expected %03b, actual %03b", want.lamps, got.lamps);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in                   in_data = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out                  o_out_data;
    logic                  o_cfg_ready;

    lamp_mode_scoreboard sb;
    int  drives_checked = 0;
    int  idle_cycles = 0;
    bit  steady = 1'b0;

    // Bits are {ignition, auto, engine, unlock}. The first eight run with every
    // register at reset, the rest after the directed settings are loaded.
    logic [3:0] early_ticks[$] = '{
        4'b0001, 4'b1000, 4'b1100, 4'b1110, 4'b1010, 4'b1110, 4'b1100, 4'b0100,
        4'b0001, 4'b1000, 4'b0000, 4'b0001, 4'b1110, 4'b1100, 4'b1110, 4'b1100,
        4'b0100, 4'b1101, 4'b1110, 4'b0000, 4'b0110, 4'b1011, 4'b0010, 4'b0001,
        4'b1100
    };

    auto_lamp_mode_controller u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && o_cfg_ready) begin
                sb.note_config(cfg_index, cfg_data);
            end
            if (o_out_valid && out_ready) begin
                sb.check_drive(o_out_data);
                drives_checked <= drives_checked + 1;
            end
            if (in_valid && o_in_ready) begin
                sb.note_tick(in_data);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_tick(input t_in v);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= v;
        do @(posedge clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!o_cfg_ready);
    endtask

    // Drops valid and waits until every owed item has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_drive.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic load_settings(input logic [7:0] ws, input logic [7:0] gs,
                                 input logic [7:0] wl, input logic [7:0] gl,
                                 input logic [7:0] ae, input logic [7:0] al);
        write_reg(CFG_WELCOME_SECONDS, ws);
        write_reg(CFG_GOODBYE_SECONDS, gs);
        write_reg(CFG_WELCOME_LAMPS, wl);
        write_reg(CFG_GOODBYE_LAMPS, gl);
        write_reg(CFG_ACC_LAMPS_ENABLED, ae);
        write_reg(CFG_ACC_LAMPS, al);
        // Writes to unmapped indexes must leave every register alone.
        write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI, 8'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly realistic driving: one switch moves at a time and is then held,
    // sometimes long enough for welcome or goodbye to time out. The rest is noise.
    task automatic drive_random(input int n_items);
        t_in cur;
        t_in v;
        int  run;
        int  sent;
        int  k;
        cur = '0;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 24) == 0) begin
                steady = ~steady;
            end
            if ($urandom_range(0, 99) < 15) begin
                send_tick(t_in'(4'($urandom_range(0, 15))));
                sent++;
            end else begin
                case ($urandom_range(0, 2))
                    0: cur.ignition_on = ~cur.ignition_on;
                    1: cur.auto_selected = ~cur.auto_selected;
                    default: cur.engine_running = ~cur.engine_running;
                endcase
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 130) : $urandom_range(1, 6);
                for (k = 0; k < run && sent < n_items; k++) begin
                    v = cur;
                    v.unlock_event = (k == 0) ? ($urandom_range(0, 3) == 0)
                                              : ($urandom_range(0, 49) == 0);
                    send_tick(v);
                    sent++;
                end
            end
        end
    endtask

    function automatic logic [7:0] pick_seconds();
        int r;
        r = $urandom_range(0, 3);
        if (r < 2) return 8'($urandom_range(1, 2));
        if (r == 2) return 8'd0;
        return 8'($urandom);
    endfunction

    initial begin : tick_source
        int i;
        int p;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 8; i++) begin
            send_tick(t_in'(early_ticks[i]));
        end
        settle();
        load_settings(8'd1, 8'd1, 8'd7, 8'd5, 8'd1, 8'd6);
        for (i = 8; i < early_ticks.size(); i++) begin
            send_tick(t_in'(early_ticks[i]));
        end
        drive_random(420);
        settle();

        load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        drive_random(250);
        settle();

        load_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        drive_random(300);
        settle();

        for (p = 0; p < 3; p++) begin
            load_settings(pick_seconds(), pick_seconds(), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
            drive_random(280);
            settle();
        end

        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.expected_drive.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : drive_sink
        bit held_off;
        int run;
        int stall;
        held_off = 1'b0;
        @(posedge clk);
        forever begin
            if (!held_off && drives_checked >= 300) begin
                // Long hold-off so the block backs up and stalls its input.
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 8);
                repeat (run) @(posedge clk);
                stall = pick_gap();
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

endmodule

FILE: auto_lamp_mode_controller.f
+incdir+design
design/alm_pkg.sv
design/alm_core.sv
design/auto_lamp_mode_controller.sv
tb/sv/tb_auto_lamp_mode_controller.sv
